[hdl/acl_pkg.sv]
// Shared types, constants and boot rule table for the five-tuple ACL classifier.
package acl_pkg;

	localparam int RULE_COUNT = 8;
	localparam int RULE_W     = (RULE_COUNT > 1) ? $clog2(RULE_COUNT) : 1;

	localparam logic [0:0]  OP_CLASSIFY = 1'b0;
	localparam logic [0:0]  OP_LOAD     = 1'b1;

	localparam logic [15:0] ETH_IPV4  = 16'h0800;
	localparam logic [7:0]  PROTO_TCP = 8'd6;
	localparam logic [7:0]  PROTO_UDP = 8'd17;

	typedef struct packed {
		logic [31:0] src_ip;
		logic [31:0] sip_mask;
		logic [31:0] dst_ip;
		logic [31:0] dip_mask;
		logic [7:0]  proto;
		logic [15:0] sport;
		logic [15:0] dport;
		logic        valid;
		logic        deny;
	} rule_t;

	typedef struct packed {
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [7:0]  proto;
		logic [15:0] sport;
		logic [15:0] dport;
	} hdr_t;

	typedef struct packed {
		logic              en;
		logic [RULE_W-1:0] addr;
		rule_t             rule;
	} tbl_wr_t;

	function automatic rule_t acl_boot_rule(input int k);
		rule_t r;
		r = '0;
		case (k)
			0: begin
				r.src_ip   = 32'h0A00_0063;
				r.sip_mask = 32'hFFFF_FFFF;
				r.valid    = 1'b1;
				r.deny     = 1'b1;
			end
			1: begin
				r.proto    = PROTO_TCP;
				r.dport    = 16'd23;
				r.valid    = 1'b1;
				r.deny     = 1'b1;
			end
			2: begin
				r.proto    = PROTO_TCP;
				r.dport    = 16'd135;
				r.valid    = 1'b1;
				r.deny     = 1'b1;
			end
			3: begin
				r.src_ip   = 32'h0A00_0100;
				r.sip_mask = 32'hFFFF_FF00;
				r.valid    = 1'b1;
			end
			4: begin
				r.src_ip   = 32'h0A00_0200;
				r.sip_mask = 32'hFFFF_FF00;
				r.valid    = 1'b1;
			end
			5: begin
				r.valid    = 1'b1;
				r.deny     = 1'b1;
			end
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

[hdl/acl_req_if.sv]
// Request channel: classify or rule-load items.
interface acl_req_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [2:0]  rule_index;
	logic        rule_valid;
	logic        rule_deny;
	logic [15:0] eth_type;
	logic [31:0] src_ip;
	logic [31:0] sip_mask;
	logic [31:0] dst_ip;
	logic [31:0] dip_mask;
	logic [7:0]  proto;
	logic [15:0] sport;
	logic [15:0] dport;

	modport source (
		output valid, opcode, rule_index, rule_valid, rule_deny, eth_type,
			src_ip, sip_mask, dst_ip, dip_mask, proto, sport, dport,
		input  ready
	);
	modport sink (
		input  valid, opcode, rule_index, rule_valid, rule_deny, eth_type,
			src_ip, sip_mask, dst_ip, dip_mask, proto, sport, dport,
		output ready
	);
endinterface

[hdl/acl_rsp_if.sv]
// Response channel: classification verdict items.
interface acl_rsp_if;
	logic        valid;
	logic        ready;
	logic        verdict;
	logic        rule_hit;
	logic [2:0]  rule_number;
	logic [31:0] permit_count;
	logic [31:0] deny_count;

	modport source (
		output valid, verdict, rule_hit, rule_number, permit_count, deny_count,
		input  ready
	);
	modport sink (
		input  valid, verdict, rule_hit, rule_number, permit_count, deny_count,
		output ready
	);
endinterface

[hdl/acl_rule_table.sv]
// Rule table registers, reset to the boot rules, one write and one read port.
module acl_rule_table
	import acl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  tbl_wr_t           wr,
	input  logic [RULE_W-1:0] rd_addr,
	output rule_t             rd_rule
);

	rule_t table_q [RULE_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RULE_COUNT; i++) begin
				table_q[i] <= acl_boot_rule(i);
			end
		end else if (wr.en) begin
			table_q[wr.addr] <= wr.rule;
		end
	end

	assign rd_rule = table_q[rd_addr];

endmodule

[hdl/acl_match_unit.sv]
// Shared comparator: checks one rule against the latched header.
module acl_match_unit
	import acl_pkg::*;
(
	input  rule_t rule,
	input  hdr_t  hdr,
	output logic  hit
);

	logic src_ok, dst_ok, proto_ok, sport_ok, dport_ok;

	always_comb begin
		src_ok   = ((hdr.src_ip ^ rule.src_ip) & rule.sip_mask) == 32'd0;
		dst_ok   = ((hdr.dst_ip ^ rule.dst_ip) & rule.dip_mask) == 32'd0;
		proto_ok = (rule.proto == 8'd0) || (rule.proto == hdr.proto);
		sport_ok = (rule.sport == 16'd0) || (rule.sport == hdr.sport);
		dport_ok = (rule.dport == 16'd0) || (rule.dport == hdr.dport);
		hit      = rule.valid && src_ok && dst_ok && proto_ok && sport_ok && dport_ok;
	end

endmodule

[hdl/five_tuple_acl_classifier.sv]
// Top level: first-match five-tuple ACL classifier with scan sequencer and counters.
// A rule-load item is written into the table when taken and gives no response. A classify item
// for an IPv4 frame is latched, then the rule table is scanned from entry 0 upward
// through one shared comparator, one rule per cycle, stopping at the first match
// or after the last rule; the DONE state then hands the result to the output
// register, waiting while it still holds an unread response. A non-IPv4 frame
// skips the scan and goes straight to DONE. The request side is ready only
// between items, while a finished response may still wait in the output
// register for the sink.
module five_tuple_acl_classifier
	import acl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	acl_req_if.sink   req,
	acl_rsp_if.source rsp
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]        state_q;
	logic [RULE_W-1:0] idx_q;
	logic [31:0]       permit_q, deny_q;
	logic              out_valid_q;

	hdr_t              hdr_q;
	logic              res_verdict_q, res_hit_q;
	logic [2:0]        res_num_q;
	logic              verdict_q, hit_q;
	logic [2:0]        num_q;
	logic [31:0]       permit_out_q, deny_out_q;

	tbl_wr_t           tbl_wr;
	rule_t             cur_rule;
	logic              cur_hit;
	logic              req_acc, is_load, is_ipv4, last_rule, out_load, l4_ports;

	assign req.ready = (state_q == ST_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign is_load   = (req.opcode == OP_LOAD);
	assign is_ipv4   = (req.eth_type == ETH_IPV4);
	assign l4_ports  = (req.proto == PROTO_TCP) || (req.proto == PROTO_UDP);
	assign last_rule = (idx_q == RULE_W'(RULE_COUNT - 1));
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);

	always_comb begin
		tbl_wr.en            = req_acc && is_load && (int'(req.rule_index) < RULE_COUNT);
		tbl_wr.addr          = RULE_W'(req.rule_index);
		tbl_wr.rule.src_ip   = req.src_ip;
		tbl_wr.rule.sip_mask = req.sip_mask;
		tbl_wr.rule.dst_ip   = req.dst_ip;
		tbl_wr.rule.dip_mask = req.dip_mask;
		tbl_wr.rule.proto    = req.proto;
		tbl_wr.rule.sport    = req.sport;
		tbl_wr.rule.dport    = req.dport;
		tbl_wr.rule.valid    = req.rule_valid;
		tbl_wr.rule.deny     = req.rule_deny;
	end

	acl_rule_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (tbl_wr),
		.rd_addr (idx_q),
		.rd_rule (cur_rule)
	);

	acl_match_unit u_match (
		.rule (cur_rule),
		.hdr  (hdr_q),
		.hit  (cur_hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			permit_q    <= '0;
			deny_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_acc && !is_load) begin
						idx_q   <= '0;
						state_q <= is_ipv4 ? ST_SCAN : ST_DONE;
					end
				end
				ST_SCAN: begin
					if (cur_hit) begin
						if (cur_rule.deny) begin
							deny_q <= deny_q + 32'd1;
						end else begin
							permit_q <= permit_q + 32'd1;
						end
						state_q <= ST_DONE;
					end else if (last_rule) begin
						permit_q <= permit_q + 32'd1;
						state_q  <= ST_DONE;
					end else begin
						idx_q <= idx_q + RULE_W'(1);
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc && !is_load) begin
			hdr_q.src_ip   <= req.src_ip;
			hdr_q.dst_ip   <= req.dst_ip;
			hdr_q.proto    <= req.proto;
			hdr_q.sport    <= l4_ports ? req.sport : 16'd0;
			hdr_q.dport    <= l4_ports ? req.dport : 16'd0;
			res_verdict_q  <= 1'b0;
			res_hit_q      <= 1'b0;
			res_num_q      <= 3'd0;
		end else if (state_q == ST_SCAN && cur_hit) begin
			res_verdict_q <= cur_rule.deny;
			res_hit_q     <= 1'b1;
			res_num_q     <= 3'(idx_q);
		end
		if (out_load) begin
			verdict_q    <= res_verdict_q;
			hit_q        <= res_hit_q;
			num_q        <= res_num_q;
			permit_out_q <= permit_q;
			deny_out_q   <= deny_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.verdict      = verdict_q;
	assign rsp.rule_hit     = hit_q;
	assign rsp.rule_number  = num_q;
	assign rsp.permit_count = permit_out_q;
	assign rsp.deny_count   = deny_out_q;

`ifndef SYNTHESIS
	a_one_count: assert property (@(posedge clk) disable iff (!arst_n)
		(permit_q != $past(permit_q)) |-> (deny_q == $past(deny_q)))
		else $error("both counters moved in one cycle");

	a_miss_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.rule_hit) |-> (rsp.rule_number == 3'd0 && !rsp.verdict))
		else $error("miss response carries rule number or deny");

	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && !is_load && is_ipv4) |=> (state_q == ST_SCAN && idx_q == '0))
		else $error("scan did not start at entry 0");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && is_load) |=> (state_q == ST_IDLE && $stable(permit_q)
			&& $stable(deny_q)))
		else $error("rule load disturbed sequencer or counters");

	a_count_scan: assert property (@(posedge clk) disable iff (!arst_n)
		((permit_q != $past(permit_q)) || (deny_q != $past(deny_q)))
			|-> ($past(state_q) == ST_SCAN && state_q == ST_DONE))
		else $error("counter moved outside a scan end");
`endif

endmodule
